>>> rtl/heterogeneous_core_dispatcher_core_macros.svh
// Assertion macros for the core dispatcher.
// Included by the top level; needs nothing else.
`ifndef HETEROGENEOUS_CORE_DISPATCHER_CORE_MACROS_SVH
`define HETEROGENEOUS_CORE_DISPATCHER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define HCD_ASSERT_SAME(lbl, clock, rstn, ante, cons) \
    lbl: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dispatcher check failed");
`define HCD_ASSERT_NEXT(lbl, clock, rstn, ante, cons) \
    lbl: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dispatcher check failed");
`else
`define HCD_ASSERT_SAME(lbl, clock, rstn, ante, cons)
`define HCD_ASSERT_NEXT(lbl, clock, rstn, ante, cons)
`endif
`endif

>>> rtl/hcd_pkg.sv
// Shared types, codes and helper functions of the core dispatcher.
// Used by every module of the block; depends on nothing.
package hcd_pkg;

    // Default sizes for the top-level parameters.
    localparam int NUM_CORES_DEF = 8;
    localparam int PID_BITS_DEF  = 16;

    // Fixed field widths.
    localparam int LOAD_W    = 10;
    localparam int PID_IN_W  = 16;
    localparam int CORE_IN_W = 3;
    localparam int MASK_W    = 8;

    // Item function codes.
    localparam logic FUNC_UPDATE   = 1'b0;
    localparam logic FUNC_DISPATCH = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_ASSIGNED = 2'd0;
    localparam logic [1:0] STATUS_RUNNING  = 2'd1;
    localparam logic [1:0] STATUS_NO_CORE  = 2'd2;
    localparam logic [1:0] STATUS_UPDATE   = 2'd3;

    // Workload codes.
    localparam logic [1:0] WL_INTERACTIVE = 2'd0;
    localparam logic [1:0] WL_CPU_BOUND   = 2'd1;
    localparam logic [1:0] WL_IO_BOUND    = 2'd2;
    localparam logic [1:0] WL_BACKGROUND  = 2'd3;

    // Frequency levels.
    localparam logic [1:0] FREQ_LOW  = 2'd0;
    localparam logic [1:0] FREQ_MID  = 2'd1;
    localparam logic [1:0] FREQ_HIGH = 2'd2;

    // Register indexes and reset values.
    localparam logic [1:0] REG_PERF_MASK = 2'd0;
    localparam logic [1:0] REG_LOW_THR   = 2'd1;
    localparam logic [1:0] REG_MID_THR   = 2'd2;
    localparam logic [1:0] REG_IO_THR    = 2'd3;

    localparam logic [MASK_W-1:0] PERF_MASK_RST = 8'd240;
    localparam logic [LOAD_W-1:0] LOW_THR_RST   = 10'd300;
    localparam logic [LOAD_W-1:0] MID_THR_RST   = 10'd700;
    localparam logic [LOAD_W-1:0] IO_THR_RST    = 10'd500;

    typedef struct packed {
        logic                 func;
        logic [CORE_IN_W-1:0] core_index;
        logic [LOAD_W-1:0]    core_load;
        logic                 core_busy_in;
        logic [PID_IN_W-1:0]  process_id;
        logic [1:0]           workload_type;
    } item_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [CORE_IN_W-1:0] chosen_core;
        logic [1:0]           frequency_level;
    } result_t;

    // Write enables towards the core table.
    typedef struct packed {
        logic util_we;
        logic pid_we;
        logic busy_we;
        logic busy_data;
    } store_we_t;

    // What the scan has found so far.
    typedef struct packed {
        logic match_found;
        logic pref_found;
        logic any_found;
    } scan_flags_t;

    // Interactive and cpu-bound work prefer performance cores.
    function automatic logic wants_perf(input logic [1:0] wl);
        return (wl == WL_INTERACTIVE) || (wl == WL_CPU_BOUND);
    endfunction

    // Frequency from the workload and the utilization of the chosen core.
    function automatic logic [1:0] freq_select(input logic [1:0]        wl,
                                               input logic [LOAD_W-1:0] util,
                                               input logic [LOAD_W-1:0] low_thr,
                                               input logic [LOAD_W-1:0] mid_thr,
                                               input logic [LOAD_W-1:0] io_thr);
        logic [1:0] level;
        case (wl)
            WL_INTERACTIVE: level = FREQ_HIGH;
            WL_BACKGROUND:  level = FREQ_LOW;
            WL_IO_BOUND:    level = (util <= io_thr) ? FREQ_LOW : FREQ_MID;
            default:
            begin
                if (util <= low_thr)
                    level = FREQ_LOW;
                else if (util <= mid_thr)
                    level = FREQ_MID;
                else
                    level = FREQ_HIGH;
            end
        endcase
        return level;
    endfunction

endpackage

>>> rtl/hcd_store.sv
// Core table: utilization and process memories plus the busy flags.
// Depends on hcd_pkg for the write-enable struct and field widths.
module hcd_store #(
    parameter int NUM_CORES = hcd_pkg::NUM_CORES_DEF,
    parameter int PID_BITS  = hcd_pkg::PID_BITS_DEF,
    localparam int CORE_BITS = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hcd_pkg::store_we_t          we,
    input  logic [CORE_BITS-1:0]        wr_addr,
    input  logic [hcd_pkg::LOAD_W-1:0]  wr_util,
    input  logic [PID_BITS-1:0]         wr_pid,
    input  logic [CORE_BITS-1:0]        rd_addr,
    output logic [hcd_pkg::LOAD_W-1:0]  rd_util,
    output logic [PID_BITS-1:0]         rd_pid,
    output logic                        rd_busy
);
    import hcd_pkg::*;

    logic [LOAD_W-1:0]   util_mem [NUM_CORES];
    logic [PID_BITS-1:0] pid_mem  [NUM_CORES];

    logic [NUM_CORES-1:0] util_vld_reg;
    logic [NUM_CORES-1:0] pid_vld_reg;
    logic [NUM_CORES-1:0] busy_flags_reg;

    logic [LOAD_W-1:0]   util_rdata_reg;
    logic [PID_BITS-1:0] pid_rdata_reg;
    logic                util_ok_reg;
    logic                pid_ok_reg;
    logic                busy_rdata_reg;

    // Utilization memory, one write and one registered read a cycle.
    always_ff @(posedge clk)
    begin
        if (we.util_we)
            util_mem[wr_addr] <= wr_util;
        util_rdata_reg <= util_mem[rd_addr];
    end

    // Process memory.
    always_ff @(posedge clk)
    begin
        if (we.pid_we)
            pid_mem[wr_addr] <= wr_pid;
        pid_rdata_reg <= pid_mem[rd_addr];
    end

    // Valid bits and busy flags; an entry never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            util_vld_reg   <= '0;
            pid_vld_reg    <= '0;
            busy_flags_reg <= '0;
            util_ok_reg    <= 1'b0;
            pid_ok_reg     <= 1'b0;
            busy_rdata_reg <= 1'b0;
        end
        else
        begin
            if (we.util_we)
                util_vld_reg[wr_addr] <= 1'b1;
            if (we.pid_we)
                pid_vld_reg[wr_addr] <= 1'b1;
            if (we.busy_we)
                busy_flags_reg[wr_addr] <= we.busy_data;
            util_ok_reg    <= util_vld_reg[rd_addr];
            pid_ok_reg     <= pid_vld_reg[rd_addr];
            busy_rdata_reg <= busy_flags_reg[rd_addr];
        end
    end

    assign rd_util = util_ok_reg ? util_rdata_reg : '0;
    assign rd_pid  = pid_ok_reg ? pid_rdata_reg : '0;
    assign rd_busy = busy_rdata_reg;

endmodule

>>> rtl/hcd_scan.sv
// Scan unit: takes one core entry a cycle and keeps the running match,
// the best preferred idle core and the best idle core. Depends on hcd_pkg.
module hcd_scan #(
    parameter int NUM_CORES = hcd_pkg::NUM_CORES_DEF,
    localparam int CORE_BITS = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample,
    input  logic                        first,
    input  logic [CORE_BITS-1:0]        addr,
    input  logic                        core_busy,
    input  logic [hcd_pkg::LOAD_W-1:0]  util,
    input  logic                        pid_match,
    input  logic                        want_perf,
    input  logic [hcd_pkg::MASK_W-1:0]  perf_mask,
    output hcd_pkg::scan_flags_t        flags,
    output logic [CORE_BITS-1:0]        match_idx,
    output logic [CORE_BITS-1:0]        pref_idx,
    output logic [hcd_pkg::LOAD_W-1:0]  pref_util,
    output logic [CORE_BITS-1:0]        any_idx,
    output logic [hcd_pkg::LOAD_W-1:0]  any_util
);
    import hcd_pkg::*;

    scan_flags_t          flags_reg, flags_base, flags_next;
    logic [CORE_BITS-1:0] match_idx_reg, match_idx_next;
    logic [CORE_BITS-1:0] pref_idx_reg, pref_idx_next;
    logic [CORE_BITS-1:0] any_idx_reg, any_idx_next;
    logic [LOAD_W-1:0]    pref_util_reg, pref_util_next;
    logic [LOAD_W-1:0]    any_util_reg, any_util_next;
    logic [6:0]           addr_wide;
    logic                 core_perf;

    // Cores past the mask width are efficiency cores.
    assign addr_wide = 7'(addr);
    assign core_perf = (addr_wide < 7'd8) && perf_mask[addr_wide[2:0]];

    // Fold one entry into the running results; the first entry starts afresh.
    always_comb
    begin
        flags_base     = first ? scan_flags_t'('0) : flags_reg;
        flags_next     = flags_reg;
        match_idx_next = match_idx_reg;
        pref_idx_next  = pref_idx_reg;
        pref_util_next = pref_util_reg;
        any_idx_next   = any_idx_reg;
        any_util_next  = any_util_reg;
        if (sample)
        begin
            flags_next = flags_base;
            if (core_busy && pid_match && !flags_base.match_found)
            begin
                flags_next.match_found = 1'b1;
                match_idx_next         = addr;
            end
            if (!core_busy)
            begin
                if (!flags_base.any_found || util < any_util_reg)
                begin
                    flags_next.any_found = 1'b1;
                    any_idx_next         = addr;
                    any_util_next        = util;
                end
                if ((core_perf == want_perf) &&
                    (!flags_base.pref_found || util < pref_util_reg))
                begin
                    flags_next.pref_found = 1'b1;
                    pref_idx_next         = addr;
                    pref_util_next        = util;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flags_reg <= '0;
        else
            flags_reg <= flags_next;
    end

    always_ff @(posedge clk)
    begin
        match_idx_reg <= match_idx_next;
        pref_idx_reg  <= pref_idx_next;
        pref_util_reg <= pref_util_next;
        any_idx_reg   <= any_idx_next;
        any_util_reg  <= any_util_next;
    end

    assign flags     = flags_reg;
    assign match_idx = match_idx_reg;
    assign pref_idx  = pref_idx_reg;
    assign pref_util = pref_util_reg;
    assign any_idx   = any_idx_reg;
    assign any_util  = any_util_reg;

endmodule

>>> rtl/heterogeneous_core_dispatcher_core.sv
// Top level of the core dispatcher: command port, registers, sequencer.
// Depends on hcd_pkg, hcd_store, hcd_scan and the assertion macro header.
`include "heterogeneous_core_dispatcher_core_macros.svh"

// An item is taken when start is high and busy is low. A status update
// writes the core table at once and its result strobes on done in the next
// cycle, so updates can follow one another every cycle. A dispatch reads the
// core table through its single read port, one core a cycle in the scan
// state, then passes through the drain and done states before the done
// strobe; busy drops in the strobe cycle, where the next item may be taken.
// The result is on its ports for that one cycle only: the receiver cannot
// stall it. The table needs no clearing pass after reset.
module heterogeneous_core_dispatcher_core #(
    parameter int NUM_CORES = hcd_pkg::NUM_CORES_DEF,
    parameter int PID_BITS  = hcd_pkg::PID_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  hcd_pkg::item_t   item,
    output logic             done,
    output hcd_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import hcd_pkg::*;

    localparam int CORE_BITS = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam logic [CORE_BITS-1:0] LAST_CORE = CORE_BITS'(NUM_CORES - 1);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [CORE_BITS-1:0] cnt_reg, cnt_next;
    logic                 smp_vld_reg, smp_first_reg;
    logic [CORE_BITS-1:0] smp_addr_reg;

    logic [PID_BITS-1:0]  pid_reg;
    logic [1:0]           wl_reg;

    logic [MASK_W-1:0]    perf_mask_reg;
    logic [LOAD_W-1:0]    low_thr_reg, mid_thr_reg, io_thr_reg;

    logic                 done_reg, done_next;
    result_t              result_reg, result_next;

    logic                 accept, update_acc, idx_ok, cfg_write;
    logic [PID_BITS-1:0]  pid_in;

    store_we_t            we;
    logic [CORE_BITS-1:0] wr_addr;
    logic [LOAD_W-1:0]    rd_util;
    logic [PID_BITS-1:0]  rd_pid;
    logic                 rd_busy;

    scan_flags_t          flags;
    logic [CORE_BITS-1:0] match_idx, pref_idx, any_idx, pick_idx;
    logic [LOAD_W-1:0]    pref_util, any_util, pick_util;
    logic                 assigned;

    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign update_acc = accept && (item.func == FUNC_UPDATE);
    assign idx_ok     = (32'(item.core_index) < NUM_CORES);
    assign pid_in     = PID_BITS'(item.process_id);

    // Configuration port: always ready, written in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perf_mask_reg <= PERF_MASK_RST;
            low_thr_reg   <= LOW_THR_RST;
            mid_thr_reg   <= MID_THR_RST;
            io_thr_reg    <= IO_THR_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_PERF_MASK: perf_mask_reg <= pwdata[MASK_W-1:0];
                REG_LOW_THR:   low_thr_reg   <= pwdata[LOAD_W-1:0];
                REG_MID_THR:   mid_thr_reg   <= pwdata[LOAD_W-1:0];
                REG_IO_THR:    io_thr_reg    <= pwdata[LOAD_W-1:0];
                default:       perf_mask_reg <= perf_mask_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_PERF_MASK: prdata = 32'(perf_mask_reg);
            REG_LOW_THR:   prdata = 32'(low_thr_reg);
            REG_MID_THR:   prdata = 32'(mid_thr_reg);
            REG_IO_THR:    prdata = 32'(io_thr_reg);
            default:       prdata = '0;
        endcase
    end

    // Dispatch sequencer: scan every core, drain the read pipe, decide.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.func == FUNC_DISPATCH)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == LAST_CORE)
                    state_next = ST_DRAIN;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DRAIN: state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            smp_vld_reg   <= 1'b0;
            smp_first_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            smp_vld_reg   <= (state_reg == ST_SCAN);
            smp_first_reg <= (state_reg == ST_SCAN) && (cnt_reg == '0);
            done_reg      <= done_next;
        end
    end

    // Item payload and the address that goes with each read.
    always_ff @(posedge clk)
    begin
        smp_addr_reg <= cnt_reg;
        result_reg   <= result_next;
        if (accept)
        begin
            pid_reg <= pid_in;
            wl_reg  <= item.workload_type;
        end
    end

    // Final choice: a running match wins, then a preferred core, then any.
    assign assigned  = !flags.match_found && (flags.pref_found || flags.any_found);
    assign pick_idx  = flags.pref_found ? pref_idx : any_idx;
    assign pick_util = flags.pref_found ? pref_util : any_util;

    always_comb
    begin
        done_next   = 1'b0;
        result_next = '0;
        if (update_acc)
        begin
            done_next          = 1'b1;
            result_next.status = STATUS_UPDATE;
        end
        else if (state_reg == ST_DONE)
        begin
            done_next = 1'b1;
            if (flags.match_found)
            begin
                result_next.status      = STATUS_RUNNING;
                result_next.chosen_core = CORE_IN_W'(match_idx);
            end
            else if (assigned)
            begin
                result_next.status          = STATUS_ASSIGNED;
                result_next.chosen_core     = CORE_IN_W'(pick_idx);
                result_next.frequency_level = freq_select(wl_reg, pick_util, low_thr_reg,
                                                          mid_thr_reg, io_thr_reg);
            end
            else
            begin
                result_next.status = STATUS_NO_CORE;
            end
        end
    end

    // Table writes: status updates on transfer, assignments when decided.
    always_comb
    begin
        we      = '0;
        wr_addr = CORE_BITS'(item.core_index);
        if (update_acc)
        begin
            we.util_we   = idx_ok;
            we.busy_we   = idx_ok;
            we.busy_data = item.core_busy_in;
        end
        else if (state_reg == ST_DONE && assigned)
        begin
            we.pid_we    = 1'b1;
            we.busy_we   = 1'b1;
            we.busy_data = 1'b1;
            wr_addr      = pick_idx;
        end
    end

    hcd_store #(
        .NUM_CORES (NUM_CORES),
        .PID_BITS  (PID_BITS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (we),
        .wr_addr (wr_addr),
        .wr_util (item.core_load),
        .wr_pid  (pid_reg),
        .rd_addr (cnt_reg),
        .rd_util (rd_util),
        .rd_pid  (rd_pid),
        .rd_busy (rd_busy)
    );

    hcd_scan #(
        .NUM_CORES (NUM_CORES)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (smp_vld_reg),
        .first     (smp_first_reg),
        .addr      (smp_addr_reg),
        .core_busy (rd_busy),
        .util      (rd_util),
        .pid_match (rd_pid == pid_reg),
        .want_perf (wants_perf(wl_reg)),
        .perf_mask (perf_mask_reg),
        .flags     (flags),
        .match_idx (match_idx),
        .pref_idx  (pref_idx),
        .pref_util (pref_util),
        .any_idx   (any_idx),
        .any_util  (any_util)
    );

    assign done   = done_reg;
    assign result = result_reg;

    // A decision always ends in a strobe, and a strobe never comes mid-dispatch.
    `HCD_ASSERT_NEXT(a_done_after_decide, clk, rst_n, state_reg == ST_DONE, done)
    `HCD_ASSERT_SAME(a_idle_when_done, clk, rst_n, done, !busy)
    // A status update answers in the next cycle with update done.
    `HCD_ASSERT_NEXT(a_update_answer, clk, rst_n, update_acc, done && result.status == STATUS_UPDATE)
    // The scan always covers the last core before a decision is made.
    `HCD_ASSERT_SAME(a_scan_drains, clk, rst_n, state_reg == ST_DRAIN, smp_vld_reg && smp_addr_reg == LAST_CORE)

endmodule
